// ===== rtl/hmdp_pkg.sv =====
// Shared types, item codes and helpers for the HID mouse descriptor parser.
`timescale 1ns / 1ps
`default_nettype none
package hmdp_pkg;

	localparam int USAGE_QUEUE_DEPTH = 8;
	localparam int OFFSET_BITS       = 12;
	localparam int QIDX_W            = (USAGE_QUEUE_DEPTH > 1) ? $clog2(USAGE_QUEUE_DEPTH) : 1;
	localparam int QFILL_W           = $clog2(USAGE_QUEUE_DEPTH + 1);
	localparam int OFS_OUT_W         = 12;
	localparam int AMT_W             = 16;
	localparam int SUM_W             = ((OFFSET_BITS > AMT_W) ? OFFSET_BITS : AMT_W) + 1;

	localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

	localparam logic [1:0] TYPE_MAIN   = 2'd0;
	localparam logic [1:0] TYPE_GLOBAL = 2'd1;
	localparam logic [1:0] TYPE_LOCAL  = 2'd2;
	localparam logic [1:0] SIZE_FOUR   = 2'd3;

	localparam logic [3:0] TAG_INPUT        = 4'd8;
	localparam logic [3:0] TAG_COLLECTION   = 4'd10;
	localparam logic [3:0] TAG_END_COLL     = 4'd12;
	localparam logic [3:0] TAG_REPORT_SIZE  = 4'd7;
	localparam logic [3:0] TAG_REPORT_ID    = 4'd8;
	localparam logic [3:0] TAG_REPORT_COUNT = 4'd9;
	localparam logic [3:0] TAG_USAGE        = 4'd0;

	localparam logic [7:0] USAGE_POINTER = 8'h01;
	localparam logic [7:0] USAGE_MOUSE   = 8'h02;
	localparam logic [7:0] USAGE_X       = 8'h30;
	localparam logic [7:0] USAGE_Y       = 8'h31;
	localparam logic [7:0] USAGE_WHEEL   = 8'h38;

	localparam logic [7:0] DEPTH_OUTER = 8'd0;
	localparam logic [7:0] DEPTH_INNER = 8'd1;
	localparam logic [7:0] DEPTH_QUEUE = 8'd2;

	localparam logic [AMT_W-1:0] REPORT_ID_BITS = 16'd8;

	localparam int LOC_X     = 0;
	localparam int LOC_Y     = 1;
	localparam int LOC_WHEEL = 2;
	localparam int LOC_BTN   = 3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic                 desc_valid;
		logic [3:0]           fields_found;
		logic [OFS_OUT_W-1:0] x_offset;
		logic [7:0]           x_width;
		logic [OFS_OUT_W-1:0] y_offset;
		logic [7:0]           y_width;
		logic [OFS_OUT_W-1:0] wheel_offset;
		logic [7:0]           wheel_width;
		logic [OFS_OUT_W-1:0] button_offset;
		logic [7:0]           button_count;
		logic [7:0]           report_id;
	} result_t;

	function automatic logic [2:0] data_len(input logic [1:0] code);
		return (code == SIZE_FOUR) ? 3'd4 : {1'b0, code};
	endfunction

	function automatic logic [OFFSET_BITS-1:0] sat_add(input logic [OFFSET_BITS-1:0] pos,
			input logic [AMT_W-1:0] amt);
		logic [SUM_W-1:0] s;
		s = SUM_W'(pos) + SUM_W'(amt);
		if (s > SUM_W'(POS_MAX)) begin
			return POS_MAX;
		end
		return s[OFFSET_BITS-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/hid_mouse_descriptor_parser_top.sv =====
// HID mouse report descriptor parser, top level with result register.
// Descriptor bytes enter on the input channel; each byte is first captured,
// then decoded and applied to the parse state. A relative Input item of a
// mouse pointer then drains its queued usages, read back from the usage queue
// RAM one entry per cycle, and the byte marked last loads the result. The
// result sits in an output register, so a new descriptor may start while it
// waits; a second result waits for that register to empty.
`timescale 1ns / 1ps
`default_nettype none
module hid_mouse_descriptor_parser_top
	import hmdp_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [7:0]           desc_byte,
	input  wire logic                 last_byte,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      desc_valid,
	output logic [3:0]                fields_found,
	output logic [OFS_OUT_W-1:0]      x_offset,
	output logic [7:0]                x_width,
	output logic [OFS_OUT_W-1:0]      y_offset,
	output logic [7:0]                y_width,
	output logic [OFS_OUT_W-1:0]      wheel_offset,
	output logic [7:0]                wheel_width,
	output logic [OFS_OUT_W-1:0]      button_offset,
	output logic [7:0]                button_count,
	output logic [7:0]                report_id
);

	logic    out_valid_q;
	result_t res_q;
	result_t res;
	logic    emit;
	logic    out_free;

	assign out_free = !out_valid_q || !out_stall;

	hmdp_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.desc_byte(desc_byte),
		.last_byte(last_byte),
		.out_free (out_free),
		.emit     (emit),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign desc_valid    = res_q.desc_valid;
	assign fields_found  = res_q.fields_found;
	assign x_offset      = res_q.x_offset;
	assign x_width       = res_q.x_width;
	assign y_offset      = res_q.y_offset;
	assign y_width       = res_q.y_width;
	assign wheel_offset  = res_q.wheel_offset;
	assign wheel_width   = res_q.wheel_width;
	assign button_offset = res_q.button_offset;
	assign button_count  = res_q.button_count;
	assign report_id     = res_q.report_id;

endmodule
`default_nettype wire

// ===== rtl/hmdp_ram.sv =====
// Simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module hmdp_ram #(
	parameter int DEPTH = 8,
	parameter int WIDTH = 8,
	parameter int AW    = 3
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/hmdp_core.sv =====
// Item decoder, parse state and usage queue drain sequencer.
`timescale 1ns / 1ps
`default_nettype none
module hmdp_core
	import hmdp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] desc_byte,
	input  wire logic       last_byte,
	input  wire logic       out_free,
	output logic            emit,
	output result_t         res
);

	state_t state_q, state_d;

	logic [7:0]             byte_q;
	logic                   last_q;
	logic [7:0]             hdr_q;
	logic [2:0]             left_q;
	logic [7:0]             depth_q;
	logic [7:0]             size_q;
	logic [7:0]             count_q;
	logic [AMT_W-1:0]       prod_q;
	logic [OFFSET_BITS-1:0] pos_q;
	logic [7:0]             outer_q;
	logic [7:0]             inner_q;
	logic [QFILL_W-1:0]     fill_q;
	logic                   failed_q;
	logic [OFS_OUT_W-1:0]   ofs_q [4];
	logic [7:0]             wid_q [4];
	logic [3:0]             found_q;
	logic [7:0]             rid_q;
	logic [QFILL_W-1:0]     proc_idx_q;

	logic                   accept;
	logic                   item_fire;
	logic [7:0]             item_hdr;
	logic [7:0]             item_val;
	logic                   is_main, is_global, is_local;
	logic                   do_input, in_const, in_rel, in_abs, rel_bad, drain_start;
	logic                   do_coll, do_end, do_size, do_count, do_rid, do_usage;
	logic                   push, overflow;
	logic [QFILL_W-1:0]     proc_next;
	logic                   drain_last;
	logic                   ram_re;
	logic [QIDX_W-1:0]      ram_raddr;
	logic [7:0]             ram_rdata;

	assign accept = in_valid && !in_stall;

	always_comb begin
		item_fire = 1'b0;
		item_hdr  = hdr_q;
		item_val  = byte_q;
		if (left_q == 3'd0) begin
			item_hdr  = byte_q;
			item_val  = 8'h00;
			item_fire = (data_len(byte_q[1:0]) == 3'd0);
		end else begin
			item_fire = (left_q == data_len(hdr_q[1:0]));
		end
		item_fire = item_fire && (state_q == ST_EXEC) && !failed_q;
	end

	assign is_main   = item_fire && (item_hdr[3:2] == TYPE_MAIN);
	assign is_global = item_fire && (item_hdr[3:2] == TYPE_GLOBAL);
	assign is_local  = item_fire && (item_hdr[3:2] == TYPE_LOCAL);

	assign do_input = is_main && (item_hdr[7:4] == TAG_INPUT)
		&& (outer_q == USAGE_MOUSE) && (inner_q == USAGE_POINTER);
	assign in_const    = do_input && item_val[0];
	assign in_rel      = do_input && !item_val[0] && item_val[2];
	assign in_abs      = do_input && !item_val[0] && !item_val[2];
	assign rel_bad     = in_rel && (8'(fill_q) != count_q);
	assign drain_start = in_rel && !rel_bad && (fill_q != '0);

	assign do_coll  = is_main && (item_hdr[7:4] == TAG_COLLECTION);
	assign do_end   = is_main && (item_hdr[7:4] == TAG_END_COLL);
	assign do_size  = is_global && (item_hdr[7:4] == TAG_REPORT_SIZE);
	assign do_count = is_global && (item_hdr[7:4] == TAG_REPORT_COUNT);
	assign do_rid   = is_global && (item_hdr[7:4] == TAG_REPORT_ID);
	assign do_usage = is_local && (item_hdr[7:4] == TAG_USAGE);

	assign push     = do_usage && (depth_q == DEPTH_QUEUE)
		&& (fill_q < QFILL_W'(USAGE_QUEUE_DEPTH));
	assign overflow = do_usage && (depth_q == DEPTH_QUEUE)
		&& (fill_q >= QFILL_W'(USAGE_QUEUE_DEPTH));

	assign proc_next  = proc_idx_q + QFILL_W'(1);
	assign drain_last = (proc_next == fill_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (drain_start) begin
					state_d = ST_DRAIN;
				end else if (last_q) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_DRAIN: begin
				if (drain_last) begin
					state_d = last_q ? ST_EMIT : ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = 1'b1;
		emit      = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_EXEC: begin
				ram_re = drain_start;
			end
			ST_DRAIN: begin
				ram_re    = (proc_next < fill_q);
				ram_raddr = proc_next[QIDX_W-1:0];
			end
			ST_EMIT: begin
				emit = out_free;
			end
			default: in_stall = 1'b1;
		endcase
	end

	hmdp_ram #(
		.DEPTH(USAGE_QUEUE_DEPTH),
		.WIDTH(8),
		.AW   (QIDX_W)
	) u_queue (
		.clk  (clk),
		.we   (push),
		.waddr(fill_q[QIDX_W-1:0]),
		.wdata(item_val),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			byte_q     <= '0;
			last_q     <= 1'b0;
			hdr_q      <= '0;
			left_q     <= '0;
			depth_q    <= '0;
			size_q     <= '0;
			count_q    <= '0;
			prod_q     <= '0;
			pos_q      <= '0;
			outer_q    <= '0;
			inner_q    <= '0;
			fill_q     <= '0;
			failed_q   <= 1'b0;
			found_q    <= '0;
			rid_q      <= '0;
			proc_idx_q <= '0;
			for (int i = 0; i < 4; i++) begin
				ofs_q[i] <= '0;
				wid_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			prod_q  <= size_q * count_q;
			if (accept) begin
				byte_q <= desc_byte;
				last_q <= last_byte;
			end
			if (emit) begin
				hdr_q      <= '0;
				left_q     <= '0;
				depth_q    <= '0;
				size_q     <= '0;
				count_q    <= '0;
				pos_q      <= '0;
				outer_q    <= '0;
				inner_q    <= '0;
				fill_q     <= '0;
				failed_q   <= 1'b0;
				found_q    <= '0;
				rid_q      <= '0;
				proc_idx_q <= '0;
				for (int i = 0; i < 4; i++) begin
					ofs_q[i] <= '0;
					wid_q[i] <= '0;
				end
			end else begin
				if (state_q == ST_EXEC) begin
					if (left_q == 3'd0) begin
						if (data_len(byte_q[1:0]) != 3'd0) begin
							hdr_q  <= byte_q;
							left_q <= data_len(byte_q[1:0]);
						end
					end else begin
						left_q <= left_q - 3'd1;
					end
				end
				if (in_const || in_abs) begin
					pos_q <= sat_add(pos_q, prod_q);
				end
				if (in_abs) begin
					ofs_q[LOC_BTN]   <= OFS_OUT_W'(pos_q);
					wid_q[LOC_BTN]   <= count_q;
					found_q[LOC_BTN] <= 1'b1;
				end
				if (rel_bad || overflow) begin
					failed_q <= 1'b1;
				end
				if (drain_start) begin
					proc_idx_q <= '0;
				end
				if (do_coll) begin
					if (depth_q == DEPTH_OUTER) begin
						pos_q <= '0;
					end
					depth_q <= depth_q + 8'd1;
				end
				if (do_end) begin
					depth_q <= depth_q - 8'd1;
				end
				if (do_size) begin
					size_q <= item_val;
				end
				if (do_count) begin
					count_q <= item_val;
				end
				if (do_rid) begin
					pos_q <= sat_add(pos_q, REPORT_ID_BITS);
					if (outer_q == USAGE_MOUSE) begin
						rid_q <= item_val;
					end
				end
				if (push) begin
					fill_q <= fill_q + QFILL_W'(1);
				end
				if (do_usage && (depth_q == DEPTH_OUTER)) begin
					outer_q <= item_val;
				end
				if (do_usage && (depth_q == DEPTH_INNER)) begin
					inner_q <= item_val;
				end
				if (state_q == ST_DRAIN) begin
					case (ram_rdata)
						USAGE_X: begin
							ofs_q[LOC_X]   <= OFS_OUT_W'(pos_q);
							wid_q[LOC_X]   <= size_q;
							found_q[LOC_X] <= 1'b1;
						end
						USAGE_Y: begin
							ofs_q[LOC_Y]   <= OFS_OUT_W'(pos_q);
							wid_q[LOC_Y]   <= size_q;
							found_q[LOC_Y] <= 1'b1;
						end
						USAGE_WHEEL: begin
							ofs_q[LOC_WHEEL]   <= OFS_OUT_W'(pos_q);
							wid_q[LOC_WHEEL]   <= size_q;
							found_q[LOC_WHEEL] <= 1'b1;
						end
						default: begin
						end
					endcase
					pos_q      <= sat_add(pos_q, AMT_W'(size_q));
					proc_idx_q <= proc_next;
					if (drain_last) begin
						fill_q <= '0;
					end
				end
			end
		end
	end

	always_comb begin
		res.desc_valid    = !failed_q;
		res.fields_found  = found_q;
		res.x_offset      = ofs_q[LOC_X];
		res.x_width       = wid_q[LOC_X];
		res.y_offset      = ofs_q[LOC_Y];
		res.y_width       = wid_q[LOC_Y];
		res.wheel_offset  = ofs_q[LOC_WHEEL];
		res.wheel_width   = wid_q[LOC_WHEEL];
		res.button_offset = ofs_q[LOC_BTN];
		res.button_count  = wid_q[LOC_BTN];
		res.report_id     = rid_q;
	end

endmodule
`default_nettype wire
